/* sv/hrf_pkg.sv */
// ----------------------------------------------------------------------------
// hrf_pkg
// Shared types, codes and text constants for the HTTP response framer.
// ----------------------------------------------------------------------------
`default_nettype none

package hrf_pkg;

   typedef enum logic [3:0] {
      PH_LEAD   = 4'd0,
      PH_VER    = 4'd1,
      PH_GAP    = 4'd2,
      PH_CODE   = 4'd3,
      PH_REASON = 4'd4,
      PH_HDR    = 4'd5,
      PH_BODY   = 4'd6,
      PH_CSIZE  = 4'd7,
      PH_CDATA  = 4'd8,
      PH_CCR    = 4'd9,
      PH_CLF    = 4'd10,
      PH_DONE   = 4'd11
   } phase_type;

   localparam logic [3:0] ERR_NONE      = 4'd0;
   localparam logic [3:0] ERR_EMPTY     = 4'd1;
   localparam logic [3:0] ERR_MALFORMED = 4'd2;
   localparam logic [3:0] ERR_NO_CODE   = 4'd3;
   localparam logic [3:0] ERR_VERSION   = 4'd4;
   localparam logic [3:0] ERR_BAD_CODE  = 4'd5;
   localparam logic [3:0] ERR_BAD_LEN   = 4'd6;
   localparam logic [3:0] ERR_LEN_REQ   = 4'd7;
   localparam logic [3:0] ERR_EMPTY_CH  = 4'd8;
   localparam logic [3:0] ERR_BAD_CHSZ  = 4'd9;

   // line flag bit positions
   localparam int F_BAD1 = 0;
   localparam int F_BAD2 = 1;
   localparam int F_DIG  = 2;
   localparam int F_STOP = 3;
   localparam int F_OVF  = 4;
   localparam int F_CR   = 5;
   localparam int F_V10  = 7;

   localparam logic [4:0] NAME_SAT = 5'd18;
   localparam logic [4:0] VAL_BASE = 5'd20;
   localparam logic [4:0] CL_LEN   = 5'd14;
   localparam logic [4:0] TE_LEN   = 5'd17;

   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_LF    = 8'h0A;
   localparam logic [7:0] CH_SP    = 8'h20;
   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_COLON = 8'h3A;

   function automatic logic [7:0] fold(input logic [7:0] c);
      return (c >= "A" && c <= "Z") ? c + 8'd32 : c;
   endfunction

   function automatic logic [7:0] ver_char(input logic [4:0] i);
      logic [7:0] r;
      case (i)
         5'd0:    r = "H";
         5'd1:    r = "T";
         5'd2:    r = "T";
         5'd3:    r = "P";
         5'd4:    r = "/";
         5'd5:    r = "1";
         5'd6:    r = ".";
         default: r = 8'h00;
      endcase
      return r;
   endfunction

   function automatic logic [7:0] cl_char(input logic [4:0] i);
      logic [7:0] r;
      case (i)
         5'd0:    r = "c";
         5'd1:    r = "o";
         5'd2:    r = "n";
         5'd3:    r = "t";
         5'd4:    r = "e";
         5'd5:    r = "n";
         5'd6:    r = "t";
         5'd7:    r = "-";
         5'd8:    r = "l";
         5'd9:    r = "e";
         5'd10:   r = "n";
         5'd11:   r = "g";
         5'd12:   r = "t";
         5'd13:   r = "h";
         default: r = 8'h00;
      endcase
      return r;
   endfunction

   function automatic logic [7:0] te_char(input logic [4:0] i);
      logic [7:0] r;
      case (i)
         5'd0:    r = "t";
         5'd1:    r = "r";
         5'd2:    r = "a";
         5'd3:    r = "n";
         5'd4:    r = "s";
         5'd5:    r = "f";
         5'd6:    r = "e";
         5'd7:    r = "r";
         5'd8:    r = "-";
         5'd9:    r = "e";
         5'd10:   r = "n";
         5'd11:   r = "c";
         5'd12:   r = "o";
         5'd13:   r = "d";
         5'd14:   r = "i";
         5'd15:   r = "n";
         5'd16:   r = "g";
         default: r = 8'h00;
      endcase
      return r;
   endfunction

   function automatic logic [7:0] ch_char(input logic [2:0] i);
      logic [7:0] r;
      case (i)
         3'd0:    r = "c";
         3'd1:    r = "h";
         3'd2:    r = "u";
         3'd3:    r = "n";
         3'd4:    r = "k";
         3'd5:    r = "e";
         3'd6:    r = "d";
         default: r = 8'h00;
      endcase
      return r;
   endfunction

endpackage

`default_nettype wire

/* sv/hrf_channels.sv */
// ----------------------------------------------------------------------------
// hrf_channels
// Valid/ready channel interfaces for request bytes and framing responses.
// ----------------------------------------------------------------------------
`default_nettype none

interface hrf_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       new_message;
   modport source (output valid, data_byte, new_message, input ready);
   modport sink   (input valid, data_byte, new_message, output ready);
endinterface

interface hrf_rsp_if;
   logic        valid;
   logic        ready;
   logic        status_valid;
   logic [15:0] resp_code;
   logic        version_minor;
   logic        body_valid;
   logic [7:0]  body_byte;
   logic        chunked_seen;
   logic        finished;
   logic [3:0]  error_code;
   modport source (output valid, status_valid, resp_code, version_minor, body_valid,
                   body_byte, chunked_seen, finished, error_code, input ready);
   modport sink   (input valid, status_valid, resp_code, version_minor, body_valid,
                   body_byte, chunked_seen, finished, error_code, output ready);
endinterface

`default_nettype wire

/* sv/http_response_framer.sv */
// ----------------------------------------------------------------------------
// http_response_framer
// Parses an HTTP/1.x response byte stream: status line, length headers,
// and frames body bytes by Content-Length or chunked encoding.
// ----------------------------------------------------------------------------
//  channel    dir  payload                               transfer
//  req_chan   in   data_byte, new_message                valid & ready
//  rsp_chan   out  status/body/framing fields            valid & ready
//
//  One byte per cycle while the response is not stalled; parser state updates in the cycle the byte is taken.
//  The response is registered; one response per request, offered in the cycle after the byte is taken.
//  A stalled response blocks input only while the output register is full.
//  Synchronous reset puts the parser at the start of a status line.
// ----------------------------------------------------------------------------
`default_nettype none

module http_response_framer
   import hrf_pkg::*;
#(
   parameter int LENGTH_BITS = 32
) (
   input  wire logic clock,
   input  wire logic reset,
   hrf_req_if.sink   req_chan,
   hrf_rsp_if.source rsp_chan
);

   localparam int LB = LENGTH_BITS;

   typedef struct packed {
      phase_type      phase;
      logic [4:0]     mi;
      logic [7:0]     flags;
      logic [LB-1:0]  acc;
      logic [LB-1:0]  rem;
      logic           len_known;
      logic           chunked;
      logic [2:0]     cm;
      logic [15:0]    held;
      logic [3:0]     err;
      logic           stv;
   } st_type;

   function automatic st_type st_reset();
      st_type s;
      s           = '0;
      s.phase     = PH_LEAD;
      s.held      = 16'd200;
      return s;
   endfunction

   function automatic st_type acc_digit(st_type s, logic [3:0] d, logic hex);
      logic [LB+3:0] w;
      logic          ovf;
      if (s.flags[F_STOP]) return s;
      if (hex) begin
         ovf = |s.acc[LB-1:LB-4];
         w   = {s.acc, 4'b0} | {{LB{1'b0}}, d};
      end else begin
         w   = {1'b0, s.acc, 3'b0} + {3'b0, s.acc, 1'b0} + {{LB{1'b0}}, d};
         ovf = |w[LB+3:LB];
      end
      if (ovf) begin
         s.flags[F_OVF]  = 1'b1;
         s.flags[F_STOP] = 1'b1;
      end else begin
         s.acc          = w[LB-1:0];
         s.flags[F_DIG] = 1'b1;
      end
      return s;
   endfunction

   function automatic st_type hdr_char(st_type s, logic [7:0] c);
      logic [4:0] i;
      logic [7:0] fc;
      i  = s.mi;
      fc = fold(c);
      if (i < VAL_BASE) begin
         if (c == CH_COLON) begin
            if (i == CL_LEN && !s.flags[F_BAD1])      s.mi = VAL_BASE + 5'd1;
            else if (i == TE_LEN && !s.flags[F_BAD2]) s.mi = VAL_BASE + 5'd2;
            else                                      s.mi = VAL_BASE;
            return s;
         end
         if (i >= CL_LEN || fc != cl_char(i)) s.flags[F_BAD1] = 1'b1;
         if (i >= TE_LEN || fc != te_char(i)) s.flags[F_BAD2] = 1'b1;
         if (i < NAME_SAT) s.mi = i + 5'd1;
         return s;
      end
      if (i < VAL_BASE + 5'd4) begin
         s.mi = i + 5'd4;
         if (c == CH_SP) return s;
      end
      if (i[1:0] == 2'd1) begin
         if (c >= "0" && c <= "9") s = acc_digit(s, c[3:0], 1'b0);
         else                      s.flags[F_STOP] = 1'b1;
      end else if (i[1:0] == 2'd2 && s.cm < 3'd7) begin
         if (c == ch_char(s.cm)) s.cm = s.cm + 3'd1;
         else                    s.cm = (c == "c") ? 3'd1 : 3'd0;
      end
      return s;
   endfunction

   function automatic st_type line_char(st_type s, logic [7:0] c);
      logic [4:0]  i;
      logic [7:0]  fc;
      logic [15:0] sc;
      fc = fold(c);
      if (s.phase == PH_LEAD) begin
         if (c == CH_SP || c == CH_TAB) return s;
         s.phase = PH_VER;
         s.mi    = 5'd0;
      end
      if (s.phase == PH_VER) begin
         if (c == CH_SP) begin
            if (s.mi != 5'd8) s.flags[F_BAD1] = 1'b1;
            s.phase = PH_GAP;
            return s;
         end
         i = s.mi;
         if (i < 5'd7) begin
            if (c != ver_char(i)) s.flags[F_BAD1] = 1'b1;
         end else if (i == 5'd7) begin
            if (c == "1")      s.flags[F_BAD2] = 1'b1;
            else if (c != "0") s.flags[F_BAD1] = 1'b1;
         end else begin
            s.flags[F_BAD1] = 1'b1;
         end
         if (i < 5'd8) s.mi = i + 5'd1;
         return s;
      end
      if (s.phase == PH_GAP) begin
         if (c == CH_SP) return s;
         s.phase = PH_CODE;
      end
      if (s.phase == PH_CODE) begin
         if (c == CH_SP) begin
            s.phase = PH_REASON;
            return s;
         end
         if (s.flags[F_STOP]) return s;
         if (c >= "0" && c <= "9") begin
            sc             = {s.acc[12:0], 3'b0} + {s.acc[14:0], 1'b0}
                             + {12'd0, c[3:0]};
            s.acc          = {{(LB-16){1'b0}}, sc};
            s.flags[F_DIG] = 1'b1;
         end else begin
            s.flags[F_STOP] = 1'b1;
         end
         return s;
      end
      if (s.phase == PH_HDR) return hdr_char(s, c);
      if (s.phase == PH_CSIZE) begin
         s.mi = 5'd1;
         if (c >= "0" && c <= "9")        s = acc_digit(s, c[3:0], 1'b1);
         else if (fc >= "a" && fc <= "f") s = acc_digit(s, fc[3:0] + 4'd9, 1'b1);
         else                             s.flags[F_STOP] = 1'b1;
      end
      return s;
   endfunction

   function automatic st_type line_end(st_type s);
      logic [1:0] kind;
      case (s.phase)
         PH_LEAD: s.err = ERR_EMPTY;
         PH_VER:  s.err = ERR_MALFORMED;
         PH_GAP, PH_CODE: s.err = ERR_NO_CODE;
         PH_REASON: begin
            if (s.flags[F_BAD1]) begin
               s.err = ERR_VERSION;
            end else begin
               s.flags[F_V10] = !s.flags[F_BAD2];
               if (!s.flags[F_DIG]) begin
                  s.err = ERR_BAD_CODE;
               end else begin
                  s.held  = s.acc[15:0];
                  s.stv   = 1'b1;
                  s.phase = PH_HDR;
               end
            end
         end
         PH_HDR: begin
            kind = s.mi[1:0];
            if (s.mi == 5'd0) begin
               if (s.chunked)                       s.phase = PH_CSIZE;
               else if (s.len_known && s.rem != '0) s.phase = PH_BODY;
               else                                 s.phase = PH_DONE;
            end else if (s.mi >= VAL_BASE) begin
               if (kind == 2'd1 && !s.len_known && !s.chunked) begin
                  if (!s.flags[F_DIG] || s.flags[F_OVF]) begin
                     s.err = ERR_BAD_LEN;
                  end else begin
                     s.len_known = 1'b1;
                     s.rem       = s.acc;
                  end
               end else if (kind == 2'd2 && !s.chunked && s.cm == 3'd7) begin
                  s.chunked   = 1'b1;
                  s.len_known = 1'b0;
               end
            end
         end
         PH_CSIZE: begin
            if (s.mi == 5'd0)                           s.err = ERR_EMPTY_CH;
            else if (!s.flags[F_DIG] || s.flags[F_OVF]) s.err = ERR_BAD_CHSZ;
            else if (s.acc == '0)                       s.phase = PH_DONE;
            else begin
               s.rem   = s.acc;
               s.phase = PH_CDATA;
            end
         end
         default: ;
      endcase
      s.mi    = 5'd0;
      s.flags = s.flags & (8'd1 << F_V10);
      s.acc   = '0;
      s.cm    = 3'd0;
      return s;
   endfunction

   function automatic st_type line_byte(st_type s, logic [7:0] c);
      if (c == CH_LF) begin
         s.flags[F_CR] = 1'b0;
         return line_end(s);
      end
      if (s.flags[F_CR]) begin
         s.flags[F_CR] = 1'b0;
         s = line_char(s, CH_CR);
      end
      if (c == CH_CR) s.flags[F_CR] = 1'b1;
      else            s = line_char(s, c);
      return s;
   endfunction

   st_type     st_ff, st_in;
   logic       body_v;
   logic       req_xfer;
   logic       out_v_ff, out_v_in;
   logic       o_stv_ff, o_vmin_ff, o_bv_ff, o_chk_ff, o_fin_ff;
   logic [15:0] o_code_ff;
   logic [7:0]  o_body_ff;
   logic [3:0]  o_err_ff;

   assign req_chan.ready = !out_v_ff || rsp_chan.ready;
   assign req_xfer       = req_chan.valid && req_chan.ready;

   always_comb begin
      st_type s;
      logic [7:0] c;
      c      = req_chan.data_byte;
      s      = req_chan.new_message ? st_reset() : st_ff;
      s.stv  = 1'b0;
      body_v = 1'b0;
      if (s.err == ERR_NONE) begin
         case (s.phase)
            PH_BODY: begin
               body_v = 1'b1;
               s.rem  = s.rem - LB'(1);
               if (s.rem == '0) s.phase = PH_DONE;
            end
            PH_CDATA: begin
               body_v = 1'b1;
               s.rem  = s.rem - LB'(1);
               if (s.rem == '0) s.phase = PH_CCR;
            end
            PH_CCR: begin
               if (c == CH_CR) begin
                  s.phase = PH_CLF;
               end else begin
                  s.phase = PH_CSIZE;
                  s = line_byte(s, c);
               end
            end
            PH_CLF: begin
               s.phase = PH_CSIZE;
               if (c != CH_LF) s = line_byte(s, c);
            end
            PH_DONE: begin
               if (!s.chunked && !s.len_known) s.err = ERR_LEN_REQ;
            end
            default: s = line_byte(s, c);
         endcase
      end
      st_in = s;
   end

   assign out_v_in = req_xfer || (out_v_ff && !rsp_chan.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff    <= st_reset();
         out_v_ff <= 1'b0;
      end else begin
         out_v_ff <= out_v_in;
         if (req_xfer) st_ff <= st_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         o_stv_ff  <= st_in.stv;
         o_code_ff <= st_in.held;
         o_vmin_ff <= !st_in.flags[F_V10];
         o_bv_ff   <= body_v;
         o_body_ff <= body_v ? req_chan.data_byte : 8'd0;
         o_chk_ff  <= st_in.chunked;
         o_fin_ff  <= (st_in.err == ERR_NONE) && (st_in.phase == PH_DONE);
         o_err_ff  <= st_in.err;
      end
   end

   assign rsp_chan.valid         = out_v_ff;
   assign rsp_chan.status_valid  = o_stv_ff;
   assign rsp_chan.resp_code     = o_code_ff;
   assign rsp_chan.version_minor = o_vmin_ff;
   assign rsp_chan.body_valid    = o_bv_ff;
   assign rsp_chan.body_byte     = o_body_ff;
   assign rsp_chan.chunked_seen  = o_chk_ff;
   assign rsp_chan.finished      = o_fin_ff;
   assign rsp_chan.error_code    = o_err_ff;

   a_err_sticky: assert property (@(posedge clock) disable iff (reset)
      (st_ff.err != ERR_NONE && !(req_xfer && req_chan.new_message))
      |=> st_ff.err == $past(st_ff.err))
      else $error("error code changed without new message");

   a_body_no_err: assert property (@(posedge clock) disable iff (reset)
      (out_v_ff && o_bv_ff) |-> (o_err_ff == ERR_NONE))
      else $error("body byte with error");

   a_status_ok: assert property (@(posedge clock) disable iff (reset)
      (out_v_ff && o_stv_ff) |-> (o_err_ff == ERR_NONE && !o_bv_ff))
      else $error("status valid with error or body byte");

   a_len_excl: assert property (@(posedge clock) disable iff (reset)
      !(st_ff.len_known && st_ff.chunked))
      else $error("length and chunked both active");

endmodule

`default_nettype wire

/* test/http_response_framer_tb.sv */
// ----------------------------------------------------------------------------
// http_response_framer_tb
// Drives HTTP response byte streams into the framer and checks every result
// transfer against an in-bench model of the parser, with random idling.
// ----------------------------------------------------------------------------
`default_nettype none

module http_response_framer_tb
   import hrf_pkg::*;
;
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic        status_valid;
      logic [15:0] resp_code;
      logic        version_minor;
      logic        body_valid;
      logic [7:0]  body_byte;
      logic        chunked_seen;
      logic        finished;
      logic [3:0]  error_code;
   } frame_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   bit   failed = 1'b0;

   hrf_req_if req_chan ();
   hrf_rsp_if rsp_chan ();

   http_response_framer DUT (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan.sink),
      .rsp_chan (rsp_chan.source)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   initial begin
      #20ms;
      $display("tb: failure");
      $finish;
   end

   // model state
   phase_type   m_phase;
   logic [4:0]  m_idx;
   logic [7:0]  m_flags;
   logic [63:0] m_acc;
   logic [63:0] m_remain;
   logic        m_len_known;
   logic        m_chunked;
   logic [2:0]  m_ch_match;
   logic [15:0] m_status;
   logic [3:0]  m_err;
   logic        m_st_now;

   frame_result_type expected_frames[$];
   int               burst_left = 0;

   localparam logic [63:0] LEN_MAX = 64'hFFFF_FFFF;

   function automatic logic [7:0] lower(input logic [7:0] c);
      return (c >= "A" && c <= "Z") ? c + 8'd32 : c;
   endfunction

   task automatic model_clear();
      m_phase = PH_LEAD; m_idx = '0; m_flags = '0; m_acc = '0; m_remain = '0;
      m_len_known = 0; m_chunked = 0; m_ch_match = '0; m_status = 16'd200;
      m_err = ERR_NONE; m_st_now = 0;
   endtask

   task automatic add_digit(input logic [63:0] d, input logic [63:0] base);
      if (m_flags[F_STOP]) return;
      if (m_acc > (LEN_MAX - d) / base) begin
         m_flags[F_OVF] = 1; m_flags[F_STOP] = 1;
         return;
      end
      m_acc = m_acc * base + d;
      m_flags[F_DIG] = 1;
   endtask

   task automatic header_char(input logic [7:0] c);
      logic [4:0] i;
      logic [7:0] cl, te;
      i = m_idx;
      if (i < VAL_BASE) begin
         if (c == CH_COLON) begin
            if (i == CL_LEN && !m_flags[F_BAD1]) m_idx = VAL_BASE + 5'd1;
            else if (i == TE_LEN && !m_flags[F_BAD2]) m_idx = VAL_BASE + 5'd2;
            else m_idx = VAL_BASE;
            return;
         end
         case (i)
            0: cl = "c"; 1: cl = "o"; 2: cl = "n"; 3: cl = "t"; 4: cl = "e";
            5: cl = "n"; 6: cl = "t"; 7: cl = "-"; 8: cl = "l"; 9: cl = "e";
            10: cl = "n"; 11: cl = "g"; 12: cl = "t"; 13: cl = "h"; default: cl = 0;
         endcase
         case (i)
            0: te = "t"; 1: te = "r"; 2: te = "a"; 3: te = "n"; 4: te = "s";
            5: te = "f"; 6: te = "e"; 7: te = "r"; 8: te = "-"; 9: te = "e";
            10: te = "n"; 11: te = "c"; 12: te = "o"; 13: te = "d"; 14: te = "i";
            15: te = "n"; 16: te = "g"; default: te = 0;
         endcase
         if (i >= CL_LEN || lower(c) != cl) m_flags[F_BAD1] = 1;
         if (i >= TE_LEN || lower(c) != te) m_flags[F_BAD2] = 1;
         if (i < NAME_SAT) m_idx = i + 5'd1;
         return;
      end
      if (i < VAL_BASE + 5'd4) begin
         m_idx = i + 5'd4;
         if (c == CH_SP) return;
      end
      if (((i - VAL_BASE) & 5'd3) == 5'd1) begin
         if (c >= "0" && c <= "9") add_digit(c - "0", 10);
         else m_flags[F_STOP] = 1;
      end else if (((i - VAL_BASE) & 5'd3) == 5'd2 && m_ch_match < 3'd7) begin
         logic [7:0] w;
         case (m_ch_match)
            0: w = "c"; 1: w = "h"; 2: w = "u"; 3: w = "n"; 4: w = "k"; 5: w = "e";
            default: w = "d";
         endcase
         if (c == w) m_ch_match = m_ch_match + 3'd1;
         else m_ch_match = (c == "c") ? 3'd1 : 3'd0;
      end
   endtask

   task automatic version_char(input logic [7:0] c);
      logic [7:0] v;
      if (c == CH_SP) begin
         if (m_idx != 5'd8) m_flags[F_BAD1] = 1;
         m_phase = PH_GAP;
         return;
      end
      case (m_idx)
         0: v = "H"; 1: v = "T"; 2: v = "T"; 3: v = "P"; 4: v = "/"; 5: v = "1";
         default: v = ".";
      endcase
      if (m_idx < 7) begin
         if (c != v) m_flags[F_BAD1] = 1;
      end else if (m_idx == 7) begin
         if (c == "1") m_flags[F_BAD2] = 1;
         else if (c != "0") m_flags[F_BAD1] = 1;
      end else m_flags[F_BAD1] = 1;
      if (m_idx < 8) m_idx = m_idx + 5'd1;
   endtask

   task automatic code_char(input logic [7:0] c);
      if (c == CH_SP) begin
         m_phase = PH_REASON;
         return;
      end
      if (m_flags[F_STOP]) return;
      if (c >= "0" && c <= "9") begin
         m_acc = (m_acc * 10 + (c - "0")) & 64'hFFFF;
         m_flags[F_DIG] = 1;
      end else m_flags[F_STOP] = 1;
   endtask

   task automatic line_char(input logic [7:0] c);
      case (m_phase)
         PH_LEAD: begin
            if (c == CH_SP || c == CH_TAB) return;
            m_phase = PH_VER; m_idx = '0;
            version_char(c);
         end
         PH_VER: version_char(c);
         PH_GAP: begin
            if (c == CH_SP) return;
            m_phase = PH_CODE;
            code_char(c);
         end
         PH_CODE: code_char(c);
         PH_HDR: header_char(c);
         PH_CSIZE: begin
            m_idx = 5'd1;
            if (c >= "0" && c <= "9") add_digit(c - "0", 16);
            else if (lower(c) >= "a" && lower(c) <= "f") add_digit(lower(c) - "a" + 10, 16);
            else m_flags[F_STOP] = 1;
         end
         default: ;
      endcase
   endtask

   task automatic line_end();
      logic [4:0] k;
      case (m_phase)
         PH_LEAD: m_err = ERR_EMPTY;
         PH_VER: m_err = ERR_MALFORMED;
         PH_GAP, PH_CODE: m_err = ERR_NO_CODE;
         PH_REASON: begin
            if (m_flags[F_BAD1]) m_err = ERR_VERSION;
            else begin
               m_flags[F_V10] = !m_flags[F_BAD2];
               if (!m_flags[F_DIG]) m_err = ERR_BAD_CODE;
               else begin
                  m_status = m_acc[15:0]; m_st_now = 1; m_phase = PH_HDR;
               end
            end
         end
         PH_HDR: begin
            if (m_idx == 0) begin
               if (m_chunked) m_phase = PH_CSIZE;
               else if (m_len_known && m_remain != 0) m_phase = PH_BODY;
               else m_phase = PH_DONE;
            end else if (m_idx >= VAL_BASE) begin
               k = (m_idx - VAL_BASE) & 5'd3;
               if (k == 1 && !m_len_known && !m_chunked) begin
                  if (!m_flags[F_DIG] || m_flags[F_OVF]) m_err = ERR_BAD_LEN;
                  else begin
                     m_len_known = 1; m_remain = m_acc;
                  end
               end else if (k == 2 && !m_chunked && m_ch_match == 3'd7) begin
                  m_chunked = 1; m_len_known = 0;
               end
            end
         end
         PH_CSIZE: begin
            if (m_idx == 0) m_err = ERR_EMPTY_CH;
            else if (!m_flags[F_DIG] || m_flags[F_OVF]) m_err = ERR_BAD_CHSZ;
            else if (m_acc == 0) m_phase = PH_DONE;
            else begin
               m_remain = m_acc; m_phase = PH_CDATA;
            end
         end
         default: ;
      endcase
      m_idx = '0; m_flags = m_flags & 8'h80; m_acc = '0; m_ch_match = '0;
   endtask

   task automatic line_byte(input logic [7:0] c);
      if (c == CH_LF) begin
         m_flags[F_CR] = 0;
         line_end();
         return;
      end
      if (m_flags[F_CR]) begin
         m_flags[F_CR] = 0;
         line_char(CH_CR);
      end
      if (c == CH_CR) m_flags[F_CR] = 1;
      else line_char(c);
   endtask

   task automatic predict_frame(input logic [7:0] c, input logic nm,
                                output frame_result_type r);
      logic bv;
      bv = 0;
      if (nm) model_clear();
      m_st_now = 0;
      if (m_err == ERR_NONE) begin
         case (m_phase)
            PH_BODY: begin
               bv = 1; m_remain--;
               if (m_remain == 0) m_phase = PH_DONE;
            end
            PH_CDATA: begin
               bv = 1; m_remain--;
               if (m_remain == 0) m_phase = PH_CCR;
            end
            PH_CCR: begin
               if (c == CH_CR) m_phase = PH_CLF;
               else begin
                  m_phase = PH_CSIZE; line_byte(c);
               end
            end
            PH_CLF: begin
               m_phase = PH_CSIZE;
               if (c != CH_LF) line_byte(c);
            end
            PH_DONE: if (!m_chunked && !m_len_known) m_err = ERR_LEN_REQ;
            default: line_byte(c);
         endcase
      end
      r.status_valid  = m_st_now;
      r.resp_code     = m_status;
      r.version_minor = !m_flags[F_V10];
      r.body_valid    = bv;
      r.body_byte     = bv ? c : 8'h00;
      r.chunked_seen  = m_chunked;
      r.finished      = (m_err == ERR_NONE && m_phase == PH_DONE);
      r.error_code    = m_err;
   endtask

   task automatic send_byte(input logic [7:0] c, input logic nm);
      frame_result_type r;
      int gap;
      if (burst_left == 0) begin
         gap = $urandom_range(0, 4);
         if (gap != 0) begin
            req_chan.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 20);
      end
      req_chan.valid       <= 1'b1;
      req_chan.data_byte   <= c;
      req_chan.new_message <= nm;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      predict_frame(c, nm, r);
      expected_frames.push_back(r);
      burst_left--;
   endtask

   task automatic send_text(input string s, input logic nm);
      for (int i = 0; i < s.len(); i++) send_byte(s[i], nm && i == 0);
   endtask

   // receiver stall pattern
   logic [3:0] stall_ctr = '0;
   always @(posedge clock) begin
      stall_ctr <= stall_ctr + 4'd1;
      rsp_chan.ready <= reset ? 1'b0 : (stall_ctr[3] ? ($urandom_range(0, 2) != 0) : 1'b1);
   end

   always @(posedge clock) begin
      frame_result_type got, want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         got = '{rsp_chan.status_valid, rsp_chan.resp_code, rsp_chan.version_minor,
                 rsp_chan.body_valid, rsp_chan.body_byte, rsp_chan.chunked_seen,
                 rsp_chan.finished, rsp_chan.error_code};
         if (expected_frames.size() == 0) begin
            $display("%t unexpected transfer: expected none actual %p", $realtime, got);
            failed = 1;
         end else begin
            want = expected_frames.pop_front();
            if (got !== want) begin
               $display("%t mismatch: expected %p actual %p", $realtime, want, got);
               failed = 1;
            end
         end
      end
   end

   function automatic string rand_digits(input int n, input bit hex);
      string s;
      string hex_set;
      string dec_set;
      s = "";
      hex_set = "0123456789abcdefABCDEF";
      dec_set = "0123456789";
      for (int i = 0; i < n; i++)
         s = {s, string'(hex ? hex_set[$urandom_range(0, 21)]
                             : dec_set[$urandom_range(0, 9)])};
      return s;
   endfunction

   task automatic test_directed();
      send_text("HTTP/1.1 200 OK\r\nContent-Length: 3\r\n\r\nabc", 1);
      send_text("  \tHTTP/1.0 65535 X\nCONTENT-LENGTH:0\n\nz", 1);
      send_text("HTTP/1.1 404 N\r\nX: y\r\n\r\nq", 1);
      send_text("HTTP/1.1 200 OK\r\nTransfer-Encoding: gzip, chunked\r\n"
                , 1);
      send_text("Content-Length: 9\r\n\r\nA\r\n0123456789\r\n0\r\n\r\n", 0);
      send_text("\r\n", 1);
      send_text("HTTP/1.1\n", 1);
      send_text("HTTP/1.1 200\n", 1);
      send_text("HTTP/2.0 200 x\n", 1);
      send_text("HTTP/1.1 abc x\n", 1);
      send_text("HTTP/1.1 1 x\nContent-Length: 99999999999\n", 1);
      send_text("HTTP/1.1 1 x\ntransfer-encoding:chunked\n\n\n", 1);
      send_text("HTTP/1.1 1 x\ntransfer-encoding:chunked\n\nzz\n", 1);
      send_text("HTTP/1.1 1 x\ntransfer-encoding:chunked\n\n1FFFFFFFF\n", 1);
      send_text("HTTP/1.1 999999 \rx\n\n", 1);
      send_byte(8'hFF, 1); send_byte(8'h00, 0); send_byte(8'h0A, 0);
   endtask

   task automatic test_random();
      int sent;
      string s, body;
      int n, sel;
      sent = 0;
      while (sent < 800) begin
         sel = $urandom_range(0, 9);
         s = {string'(($urandom_range(0, 3) == 0) ? " " : ""),
              ($urandom_range(0, 9) == 0) ? "HTTP/1.2" :
              ($urandom_range(0, 1) ? "HTTP/1.1" : "HTTP/1.0"), " ",
              rand_digits($urandom_range(1, 6), 0), " R\r\n"};
         if ($urandom_range(0, 2) == 0) s = {s, "Host: a\r\n"};
         if (sel < 4) begin
            n = $urandom_range(0, 12);
            body = "";
            for (int i = 0; i < n; i++) body = {body, string'(8'($urandom_range(0, 255)))};
            s = {s, "content-Length: ", $sformatf("%0d", n), "\r\n\r\n", body};
         end else if (sel < 8) begin
            s = {s, "Transfer-Encoding: chunked\r\n\r\n"};
            repeat ($urandom_range(0, 3)) begin
               n = $urandom_range(1, 9);
               s = {s, $sformatf("%0h", n), ($urandom_range(0, 1) ? ";x" : ""), "\r\n"};
               for (int i = 0; i < n; i++) s = {s, string'(8'($urandom_range(0, 255)))};
               s = {s, ($urandom_range(0, 3) == 0) ? "" : "\r\n"};
            end
            s = {s, ($urandom_range(0, 5) == 0) ? rand_digits(3, 1) : "0", "\r\n\r\n"};
         end else if (sel == 8) begin
            s = {s, "\r\n"};
         end else begin
            n = $urandom_range(1, 30);
            s = "";
            for (int i = 0; i < n; i++) s = {s, string'(8'($urandom_range(0, 255)))};
         end
         send_text(s, 1);
         sent += s.len();
      end
   endtask

   initial begin
      req_chan.valid       <= 1'b0;
      req_chan.data_byte   <= 8'h00;
      req_chan.new_message <= 1'b0;
      model_clear();
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_random();
      req_chan.valid <= 1'b0;
      while (expected_frames.size() != 0) @(posedge clock);
      repeat (5) @(posedge clock);
      if (!failed) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule

`default_nettype wire

/* sim.f */
sv/hrf_pkg.sv
sv/hrf_channels.sv
sv/http_response_framer.sv
test/http_response_framer_tb.sv
